// ----- hw/rtl/scmk_pkg.sv -----
// Shared widths, constants and item types for the spatial cell Morton key block.
// No dependencies; every other file refers to this package by scoped names.
`timescale 1ns / 1ps

package scmk_pkg;

	localparam int IDX_W          = 24;
	localparam int POS_W          = 24;
	localparam int POS_FRAC_BITS  = 8;
	localparam int QUANT_BITS     = 16;
	localparam int CELL_W         = 16;
	localparam int KEY_W          = 32;
	localparam int SHIFT_W        = 4;
	// total shift is cell_shift + POS_FRAC_BITS, at most 15 + 8
	localparam int SH_W           = 5;
	localparam int CELL_MAX       = (1 << (CELL_W - 1)) - 1;
	localparam logic [SHIFT_W-1:0] CELL_SHIFT_RST = SHIFT_W'(7);

	localparam int IN_W  = IDX_W + 2 * POS_W;
	localparam int OUT_W = IDX_W + 2 * CELL_W + KEY_W;

	typedef struct packed {
		logic signed [POS_W-1:0] pos_z;
		logic signed [POS_W-1:0] pos_x;
		logic [IDX_W-1:0]        src_idx;
	} point_t;

	typedef struct packed {
		logic [KEY_W-1:0]         morton_key;
		logic signed [CELL_W-1:0] cell_row;
		logic signed [CELL_W-1:0] cell_col;
		logic [IDX_W-1:0]         index_out;
	} result_t;

endpackage

// ----- hw/rtl/scmk_place.sv -----
// Floors one coordinate to its grid cell and quantizes the offset inside the cell.
// Depends on scmk_pkg.
`timescale 1ns / 1ps

module scmk_place (
	input  logic signed [scmk_pkg::POS_W-1:0]  pos,
	input  logic [scmk_pkg::SH_W-1:0]          sh,
	output logic signed [scmk_pkg::CELL_W-1:0] cell_idx,
	output logic [scmk_pkg::QUANT_BITS-1:0]    q
);

	localparam int FW = scmk_pkg::POS_W - 1;
	localparam int VW = scmk_pkg::POS_W + scmk_pkg::QUANT_BITS + 1;
	localparam logic signed [scmk_pkg::POS_W-1:0] CMAX = scmk_pkg::POS_W'(scmk_pkg::CELL_MAX);
	localparam logic signed [scmk_pkg::POS_W-1:0] CMIN = -CMAX - scmk_pkg::POS_W'(1);

	logic [scmk_pkg::SH_W-1:0]         shl;
	logic [FW-1:0]                     mask;
	logic [FW-1:0]                     off;
	logic [FW-1:0]                     frac;
	logic signed [scmk_pkg::POS_W-1:0] pos_sh;
	logic [VW-1:0]                     v;

	// Align the offset to a fixed FW-bit fraction so the rounding is a fixed slice.
	assign shl    = scmk_pkg::SH_W'(FW) - sh;
	assign mask   = {FW{1'b1}} >> shl;
	assign off    = pos[FW-1:0] & mask;
	assign frac   = off << shl;
	assign pos_sh = pos >>> sh;

	// frac * (2^Q - 1) * 2 + 2^FW, then drop FW + 1 bits
	assign v = (VW'(frac) << (scmk_pkg::QUANT_BITS + 1)) - (VW'(frac) << 1)
		+ (VW'(1) << FW);
	assign q = v[FW+1 +: scmk_pkg::QUANT_BITS];

	always_comb begin
		priority if (pos_sh > CMAX) begin
			cell_idx = scmk_pkg::CELL_W'(CMAX);
		end else if (pos_sh < CMIN) begin
			cell_idx = scmk_pkg::CELL_W'(CMIN);
		end else begin
			cell_idx = pos_sh[scmk_pkg::CELL_W-1:0];
		end
	end

endmodule

// ----- hw/rtl/scmk_spread.sv -----
// Interleaves two quantized offsets into a Morton key, X on even bits.
// Depends on scmk_pkg.
`timescale 1ns / 1ps

module scmk_spread (
	input  logic [scmk_pkg::QUANT_BITS-1:0] qx,
	input  logic [scmk_pkg::QUANT_BITS-1:0] qz,
	output logic [scmk_pkg::KEY_W-1:0]      key
);

	always_comb begin
		key = '0;
		for (int i = 0; i < scmk_pkg::QUANT_BITS; i++) begin
			key[2*i]     = qx[i];
			key[2*i + 1] = qz[i];
		end
	end

endmodule

// ----- hw/rtl/spatial_cell_morton_key_top.sv -----
// Top level of the spatial cell Morton key block: input and result registers.
// Depends on scmk_pkg, scmk_place and scmk_spread.
`timescale 1ns / 1ps

// Takes one point per transfer and returns its source index, the signed grid
// cell of X and Z (floor of position over 2^cell_shift units, saturated to
// 16 bits) and a 32-bit Morton key of the in-cell offsets, each quantized to
// 16 bits with round-half-up; X sits on the even key bits. The block takes
// one point per clock cycle while m_tready stays high. A result passes from
// the input register through the cell, quantize and interleave logic into
// the result register, where it is offered on m_tvalid until it is taken.
// The two registers form a two-entry pipeline: while a result waits for
// m_tready at most one more input transfer is taken, then s_tready drops.
// s_tready follows m_tready combinationally. Write cfg_wdata (cell_shift)
// only while the block is drained; it resets to 7.

module spatial_cell_morton_key_top (
	input  logic                            clk,
	input  logic                            arst_n,
	// cell_shift, written when cfg_we is high
	input  logic                            cfg_we,
	input  logic [scmk_pkg::SHIFT_W-1:0]    cfg_wdata,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// [23:0] source_index, [47:24] pos_x, [71:48] pos_z
	input  logic [scmk_pkg::IN_W-1:0]       s_tdata,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// [23:0] index_out, [39:24] cell_col, [55:40] cell_row, [87:56] morton_key
	output logic [scmk_pkg::OUT_W-1:0]      m_tdata
);

	logic [scmk_pkg::SHIFT_W-1:0] cell_shift_q;
	scmk_pkg::point_t             pt_s1;
	logic                         vld_s1;
	scmk_pkg::result_t            res_s2;
	logic                         vld_s2;

	logic                         adv_s2;
	logic                         load_s1;
	logic [scmk_pkg::SH_W-1:0]    sh;
	logic [scmk_pkg::QUANT_BITS-1:0] qx;
	logic [scmk_pkg::QUANT_BITS-1:0] qz;
	logic signed [scmk_pkg::CELL_W-1:0] col_d;
	logic signed [scmk_pkg::CELL_W-1:0] row_d;
	logic [scmk_pkg::KEY_W-1:0]   key_d;
	scmk_pkg::result_t            res_d;

	// Result register moves when empty or being taken; input register
	// refills whenever its item moves on.
	assign adv_s2   = !vld_s2 || m_tready;
	assign s_tready = !vld_s1 || adv_s2;
	assign load_s1  = s_tvalid && s_tready;

	assign sh = scmk_pkg::SH_W'(cell_shift_q) + scmk_pkg::SH_W'(scmk_pkg::POS_FRAC_BITS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cell_shift_q <= scmk_pkg::CELL_SHIFT_RST;
		end else if (cfg_we) begin
			cell_shift_q <= cfg_wdata;
		end
	end

	// Input register: hold the point until the result register takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s_tready) begin
			vld_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			pt_s1 <= scmk_pkg::point_t'(s_tdata);
		end
	end

	scmk_place u_place_x (
		.pos      (pt_s1.pos_x),
		.sh       (sh),
		.cell_idx (col_d),
		.q        (qx)
	);

	scmk_place u_place_z (
		.pos      (pt_s1.pos_z),
		.sh       (sh),
		.cell_idx (row_d),
		.q        (qz)
	);

	scmk_spread u_spread (
		.qx  (qx),
		.qz  (qz),
		.key (key_d)
	);

	assign res_d = {key_d, row_d, col_d, pt_s1.src_idx};

	// Result register: advance on a free slot, hold while the sink stalls.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (adv_s2) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2 && vld_s1) begin
			res_s2 <= res_d;
		end
	end

	assign m_tvalid = vld_s2;
	assign m_tdata  = res_s2;

endmodule

// ----- hw/rtl/scmk_checker.sv -----
// Port-level checks of the spatial cell Morton key pipeline, bound to the top level.
// Depends on scmk_pkg and spatial_cell_morton_key_top.
`timescale 1ns / 1ps

module scmk_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          s_tvalid,
	input logic                          s_tready,
	input logic                          m_tvalid,
	input logic                          m_tready,
	input logic [scmk_pkg::OUT_W-1:0]    m_tdata
);

	// A stalled result stays put.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// With the result slot empty the pipeline always takes input.
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input not ready with empty result slot");

	// A new result follows an input transfer through the input and result registers.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2))
		else $error("result appeared without matching input transfer");

	// Two entries only: a transfer during a stall fills the pipeline.
	a_capacity: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready && $past(m_tvalid && !m_tready)
		&& $past(s_tvalid && s_tready) |-> !s_tready)
		else $error("input accepted beyond pipeline depth");

endmodule

bind spatial_cell_morton_key_top scmk_checker u_scmk_checker (.*);
